>>> rtl/pqls_pkg.sv
package pqls_pkg;

    // request codes
    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;
    localparam logic [1:0] REQ_CLR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        item_data;
        logic signed [15:0] item_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        removed_data;
        logic signed [15:0] removed_priority;
        logic [31:0]        top_data;
        logic signed [15:0] top_priority;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_init;
        logic rd_issue;
        logic shift_mode;
        logic shift_init;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic ptr_end;
        logic rd_pending;
    } sts_t;

endpackage

>>> rtl/priority_queue_linear_scan.sv
// Bounded priority queue, entries kept in arrival order in one RAM.
// Request channel (req_valid / req_stall / req): one word per request,
// enqueue, dequeue of the highest priority (earliest on ties) or clear.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one word per
// request with status, removed entry, top entry, count and flags.
// The top entry is cached in registers, so enqueue and clear need no
// RAM scan and go from accept straight to the finish state. A dequeue
// reads every stored entry through the RAM read port to find the winner
// and the runner-up, then moves the entries above the winner down one
// place. One request is worked at a time; req_stall is high from
// accept until the response is loaded into the output register.
// The output register lets the next request be accepted while a response
// waits; a stalled response holds, and a finished request waits for it.
// Reset empties the queue and drops any pending response; RAM contents
// are not cleared and are never read before they are written.
module priority_queue_linear_scan #(
    parameter int CAPACITY       = 16,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pqls_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pqls_pkg::rsp_t rsp
);

    import pqls_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pqls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req.req_type),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    pqls_dpath #(
        .CAPACITY       (CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

>>> rtl/pqls_ram.sv
module pqls_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/pqls_ctrl.sv
module pqls_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  logic [1:0]    req_type,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pqls_pkg::cmd_t cmd,
    input  pqls_pkg::sts_t sts
);

    import pqls_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (req_type == REQ_DEQ && !sts.count_zero)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_issue = !sts.ptr_end;
                if (sts.ptr_end && !sts.rd_pending)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // pull the entries above the winner down by one
                cmd.shift_mode = 1'b1;
                cmd.rd_issue   = !sts.ptr_end;
                if (sts.ptr_end && !sts.rd_pending)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/pqls_dpath.sv
module pqls_dpath #(
    parameter int CAPACITY       = 16,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pqls_pkg::req_t req,
    output pqls_pkg::rsp_t rsp,
    input  pqls_pkg::cmd_t cmd,
    output pqls_pkg::sts_t sts
);

    import pqls_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int W  = DATA_WIDTH + PRIORITY_WIDTH;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef logic [DATA_WIDTH-1:0]            data_t;
    typedef logic signed [PRIORITY_WIDTH-1:0] prio_t;

    req_t          req_reg;
    logic [CW-1:0] count_reg, count_next;
    data_t         top_data_reg, top_data_next;
    prio_t         top_prio_reg, top_prio_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    data_t         best_data_reg, best_data_next;
    prio_t         best_prio_reg, best_prio_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    data_t         sec_data_reg, sec_data_next;
    prio_t         sec_prio_reg, sec_prio_next;
    logic          sec_vld_reg, sec_vld_next;
    rsp_t          rsp_reg, rsp_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;
    logic [W-1:0]  rd_data;
    data_t         rd_dat;
    prio_t         rd_prio;

    logic [DATA_WIDTH+31:0]     in_data_ext;
    logic [PRIORITY_WIDTH+15:0] in_prio_ext;
    data_t                      in_data;
    prio_t                      in_prio;
    logic [1:0]                 status;
    data_t                      rem_data;
    prio_t                      rem_prio;
    logic [DATA_WIDTH+31:0]     rem_data_ext, top_data_ext;
    logic [PRIORITY_WIDTH+15:0] rem_prio_ext, top_prio_ext;
    logic [CW+4:0]              count_ext;
    logic                       enq_ok;

    assign in_data_ext = {{DATA_WIDTH{1'b0}}, req_reg.item_data};
    assign in_prio_ext = {{PRIORITY_WIDTH{1'b0}}, req_reg.item_priority};
    assign in_data     = in_data_ext[DATA_WIDTH-1:0];
    assign in_prio     = in_prio_ext[PRIORITY_WIDTH-1:0];

    assign rd_dat  = rd_data[DATA_WIDTH-1:0];
    assign rd_prio = rd_data[W-1:DATA_WIDTH];

    assign enq_ok = (req_reg.req_type == REQ_ENQ) && (count_reg != CAP);

    assign sts.count_zero = (count_reg == '0);
    assign sts.ptr_end    = (ptr_reg == count_reg);
    assign sts.rd_pending = rd_vld_reg;

    assign rsp = rsp_reg;

    // single write port: compaction move or enqueue append
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {in_prio, in_data};
        if (cmd.shift_mode && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - AW'(1);
            wr_data = rd_data;
        end
        else if (cmd.commit && enq_ok)
        begin
            wr_en = 1'b1;
        end
    end

    pqls_ram #(
        .WIDTH (W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.shift_init)
        begin
            ptr_next = CW'(best_idx_reg) + CW'(1);
        end
        else if (cmd.rd_issue)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    // track the first maximum and the first maximum of the rest
    always_comb
    begin
        best_data_next = best_data_reg;
        best_prio_next = best_prio_reg;
        best_idx_next  = best_idx_reg;
        sec_data_next  = sec_data_reg;
        sec_prio_next  = sec_prio_reg;
        sec_vld_next   = sec_vld_reg;
        if (rd_vld_reg && !cmd.shift_mode)
        begin
            priority if (rd_idx_reg == '0)
            begin
                best_data_next = rd_dat;
                best_prio_next = rd_prio;
                best_idx_next  = '0;
                sec_vld_next   = 1'b0;
            end
            else if (rd_prio > best_prio_reg)
            begin
                sec_data_next  = best_data_reg;
                sec_prio_next  = best_prio_reg;
                sec_vld_next   = 1'b1;
                best_data_next = rd_dat;
                best_prio_next = rd_prio;
                best_idx_next  = rd_idx_reg;
            end
            else if (!sec_vld_reg || rd_prio > sec_prio_reg)
            begin
                sec_data_next = rd_dat;
                sec_prio_next = rd_prio;
                sec_vld_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        top_data_next = top_data_reg;
        top_prio_next = top_prio_reg;
        status        = ST_DONE;
        rem_data      = '0;
        rem_prio      = '0;
        unique case (req_reg.req_type)
            REQ_ENQ:
            begin
                if (!enq_ok)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    if (count_reg == '0 || in_prio > top_prio_reg)
                    begin
                        top_data_next = in_data;
                        top_prio_next = in_prio;
                    end
                end
            end
            REQ_DEQ:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next    = count_reg - CW'(1);
                    rem_data      = best_data_reg;
                    rem_prio      = best_prio_reg;
                    top_data_next = sec_data_reg;
                    top_prio_next = sec_prio_reg;
                end
            end
            REQ_CLR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rem_data_ext = {32'b0, rem_data};
        rem_prio_ext = {16'b0, rem_prio};
        top_data_ext = {32'b0, top_data_next};
        top_prio_ext = {16'b0, top_prio_next};
        count_ext    = {5'b0, count_next};
        if (count_next == '0)
        begin
            top_data_ext = '0;
            top_prio_ext = '0;
        end
        rsp_next.status           = status;
        rsp_next.removed_data     = rem_data_ext[31:0];
        rsp_next.removed_priority = rem_prio_ext[15:0];
        rsp_next.top_data         = top_data_ext[31:0];
        rsp_next.top_priority     = top_prio_ext[15:0];
        rsp_next.entry_count      = count_ext[4:0];
        rsp_next.is_empty         = (count_next == '0);
        rsp_next.is_full          = (count_next == CAP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        rd_idx_reg    <= ptr_reg[AW-1:0];
        best_data_reg <= best_data_next;
        best_prio_reg <= best_prio_next;
        best_idx_reg  <= best_idx_next;
        sec_data_reg  <= sec_data_next;
        sec_prio_reg  <= sec_prio_next;
        sec_vld_reg   <= sec_vld_next;
        if (cmd.commit)
        begin
            top_data_reg <= top_data_next;
            top_prio_reg <= top_prio_next;
            rsp_reg      <= rsp_next;
        end
    end

endmodule

>>> tb/priority_queue_linear_scan_tb.sv
module priority_queue_linear_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pqls_pkg::*;

    localparam int         QUEUE_DEPTH   = 16;
    localparam logic [1:0] REQ_NOP       = 2'd3;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         DRAIN_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES = 50;
    localparam int         MAX_PRINTED   = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // shadow copy of the queue, oldest entry at index 0
    logic [31:0]        shadow_data [QUEUE_DEPTH];
    logic signed [15:0] shadow_prio [QUEUE_DEPTH];
    int                 shadow_count = 0;
    rsp_t               expected_outcomes [$];

    int error_count  = 0;
    int idle_cycles  = 0;
    int req_gap_pct  = 0;
    int rsp_gap_pct  = 0;
    bit hold_off_rsp = 1'b0;

    priority_queue_linear_scan dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("%0t ERROR %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    // first entry holding the highest priority; shadow_count must be nonzero
    function automatic int best_entry();
        int best;
        int i;
        best = 0;
        for (i = 1; i < shadow_count; i++)
            if (shadow_prio[i] > shadow_prio[best])
                best = i;
        return best;
    endfunction

    function automatic rsp_t predict_queue_op(input req_t r);
        rsp_t o;
        int   idx;
        int   i;
        o = '0;
        o.status = ST_DONE;
        case (r.req_type)
            REQ_ENQ:
                if (shadow_count >= QUEUE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    shadow_data[shadow_count] = r.item_data;
                    shadow_prio[shadow_count] = r.item_priority;
                    shadow_count++;
                end
            REQ_DEQ:
                if (shadow_count == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    idx = best_entry();
                    o.removed_data     = shadow_data[idx];
                    o.removed_priority = shadow_prio[idx];
                    // close the gap, keeping arrival order
                    for (i = idx; i < shadow_count - 1; i++)
                    begin
                        shadow_data[i] = shadow_data[i + 1];
                        shadow_prio[i] = shadow_prio[i + 1];
                    end
                    shadow_count--;
                end
            REQ_CLR:
                shadow_count = 0;
            default:
                ;
        endcase
        if (shadow_count > 0)
        begin
            idx = best_entry();
            o.top_data     = shadow_data[idx];
            o.top_priority = shadow_prio[idx];
        end
        o.entry_count = 5'(shadow_count);
        o.is_empty    = (shadow_count == 0);
        o.is_full     = (shadow_count == QUEUE_DEPTH);
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [1:0] pick_op(input int enq_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2)
            return REQ_CLR;
        if (roll < 4)
            return REQ_NOP;
        if ($urandom_range(99) < enq_pct)
            return REQ_ENQ;
        return REQ_DEQ;
    endfunction

    function automatic logic signed [15:0] pick_priority();
        logic signed [15:0] p;
        case ($urandom_range(3))
            0: p = 16'($urandom_range(6)) - 16'sd3;
            1:
                case ($urandom_range(3))
                    0:       p = 16'h7FFF;
                    1:       p = 16'h8000;
                    2:       p = 16'h0000;
                    default: p = 16'hFFFF;
                endcase
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [31:0] data,
                             input logic signed [15:0] prio);
        int   gap;
        req_t w;
        gap = pick_gap(req_gap_pct);
        w.req_type      = op;
        w.item_data     = data;
        w.item_priority = prio;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        expected_outcomes.push_back(predict_queue_op(w));
    endtask

    task automatic test_directed();
        req_gap_pct = 0;
        rsp_gap_pct = 0;
        send_word(REQ_DEQ, 32'h0000_0000, 16'h0000);
        send_word(REQ_NOP, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(REQ_CLR, 32'h1234_5678, 16'h0007);
        send_word(REQ_ENQ, 32'h0000_0000, 16'h8000);
        send_word(REQ_ENQ, 32'hFFFF_FFFF, 16'h7FFF);
        // same top priority, arrives later: must lose the tie
        send_word(REQ_ENQ, 32'hA5A5_A5A5, 16'h7FFF);
        send_word(REQ_ENQ, 32'h5A5A_5A5A, 16'hFFFF);
        send_word(REQ_ENQ, 32'h0000_0001, 16'h0000);
        send_word(REQ_NOP, 32'h0000_0000, 16'h0000);
        repeat (6) send_word(REQ_DEQ, 32'hFFFF_FFFF, 16'h7FFF);
        send_word(REQ_ENQ, 32'h8000_0000, 16'h0001);
        send_word(REQ_ENQ, 32'h7FFF_FFFF, 16'h0001);
        send_word(REQ_ENQ, 32'h0F0F_0F0F, 16'h8000);
        send_word(REQ_CLR, 32'h0000_0000, 16'h0000);
        send_word(REQ_DEQ, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_fill_and_reject();
        req_gap_pct = 20;
        rsp_gap_pct = 20;
        // narrow priorities so ties pile up in a full queue
        repeat (QUEUE_DEPTH) send_word(REQ_ENQ, $urandom, 16'($urandom_range(3)));
        repeat (2) send_word(REQ_ENQ, $urandom, pick_priority());
        send_word(REQ_NOP, $urandom, pick_priority());
        send_word(REQ_DEQ, $urandom, pick_priority());
        send_word(REQ_ENQ, $urandom, 16'($urandom_range(3)));
        repeat (QUEUE_DEPTH + 1) send_word(REQ_DEQ, $urandom, pick_priority());
    endtask

    task automatic test_backpressure();
        req_gap_pct  = 0;
        rsp_gap_pct  = 0;
        hold_off_rsp = 1'b1;
        repeat (8) send_word(REQ_ENQ, $urandom, pick_priority());
        repeat (4) send_word(REQ_DEQ, $urandom, pick_priority());
    endtask

    task automatic test_random(input int n_items);
        int i;
        int enq_pct;
        enq_pct = 75;
        for (i = 0; i < n_items; i++)
        begin
            // alternate filling and draining phases, some of them without gaps
            if (i % 40 == 0)
            begin
                enq_pct = (enq_pct == 75) ? 30 : 75;
                if ((i / 40) % 4 == 0)
                begin
                    req_gap_pct = 0;
                    rsp_gap_pct = 0;
                end
                else
                begin
                    req_gap_pct = $urandom_range(50, 10);
                    rsp_gap_pct = $urandom_range(50, 10);
                end
            end
            send_word(pick_op(enq_pct), $urandom, pick_priority());
        end
    endtask

    initial
    begin : rsp_side
        int stall_len;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_rsp)
            begin
                stall_len    = HOLD_CYCLES;
                hold_off_rsp = 1'b0;
            end
            else
                stall_len = pick_gap(rsp_gap_pct);
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (expected_outcomes.size() == 0)
                report_error($sformatf("response word with none expected: %h", rsp));
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("status", 32'(rsp.status), 32'(want.status));
                check_field("removed_data", rsp.removed_data, want.removed_data);
                check_field("removed_priority", 32'(rsp.removed_priority),
                            32'(want.removed_priority));
                check_field("top_data", rsp.top_data, want.top_data);
                check_field("top_priority", 32'(rsp.top_priority),
                            32'(want.top_priority));
                check_field("entry_count", 32'(rsp.entry_count),
                            32'(want.entry_count));
                check_field("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
                check_field("is_full", 32'(rsp.is_full), 32'(want.is_full));
            end
        end
    end

    // count cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int drain_cycles;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_reject();
        test_backpressure();
        test_random(880);

        req_valid <= 1'b0;
        for (drain_cycles = 0;
             drain_cycles < DRAIN_LIMIT && expected_outcomes.size() != 0;
             drain_cycles++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_outcomes.size() != 0)
            report_error($sformatf("%0d responses never arrived",
                                   expected_outcomes.size()));

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
